// ===== design/mgv_pkg.sv =====
package mgv_pkg;

    localparam int GPOS_W = 28;
    localparam logic signed [GPOS_W-1:0] GPOS_MAX = 28'sh7ffffff;
    localparam logic signed [GPOS_W-1:0] GPOS_MIN = -28'sh8000000;
    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [15:0] HALF_Q16 = 16'h8000;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] REG_WIDTH = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_INV = 2'd2;

    typedef struct packed {
        logic        command;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic [31:0] data_u;
        logic [31:0] data_v;
    } item_t;

endpackage

// ===== design/mgv_ram.sv =====
module mgv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== design/mgv_front.sv =====
module mgv_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mgv_pkg::item_t    in_item,
    output logic              q_valid,
    input  logic              q_ready,
    output mgv_pkg::item_t    q_item
);

    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic           wp_reg;
    logic           rp_reg;
    mgv_pkg::item_t buf_reg [2];
    logic           push;
    logic           pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_item = buf_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= in_item;
        end
    end

endmodule

// ===== design/mgv_back.sv =====
module mgv_back #(
    parameter int MAX_WIDTH = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  mgv_pkg::item_t q_item,
    input  logic [6:0]     grid_width,
    input  logic [6:0]     grid_height,
    input  logic [31:0]    inv_cell_size,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    out_u,
    output logic [31:0]    out_v,
    output logic           out_sat
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int IW = 12;
    localparam int GW = mgv_pkg::GPOS_W;
    localparam int GE = GW + 1;
    localparam int WW = 30;
    localparam int ACW = 96;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MULX = 4'd1;
    localparam logic [3:0] S_MULY = 4'd2;
    localparam logic [3:0] S_NODE = 4'd3;
    localparam logic [3:0] S_RD = 4'd4;
    localparam logic [3:0] S_ACC = 4'd5;
    localparam logic [3:0] S_FIN = 4'd6;
    localparam logic [3:0] S_OUT = 4'd7;

    logic [3:0]  st_reg;
    logic [1:0]  k_reg;
    logic        kv_reg;
    logic        acc_ph_reg;
    logic signed [GW-1:0] gx_reg;
    logic signed [GW-1:0] gy_reg;
    logic signed [63:0] prod_reg;
    logic [31:0] py_reg;
    logic [IW-1:0] ui_reg, uj_reg, vi_reg, vj_reg;
    logic signed [WW-1:0] uwx1_reg, uwy1_reg, vwx1_reg, vwy1_reg;
    logic ulx_reg, uly_reg, vlx_reg, vly_reg;
    logic signed [2*WW-1:0] wxy_reg;
    logic signed [ACW-1:0] acc_u_reg, acc_v_reg;
    logic [31:0] out_u_reg, out_v_reg;
    logic out_sat_reg;
    logic out_valid_reg;

    logic [IW-1:0] w_eff, h_eff;
    logic [AW-1:0] ram_addr_u, ram_addr_v;
    logic ram_we;
    logic [31:0] ru_data, rv_data;

    assign w_eff = (grid_width == 7'd0) ? IW'(1) :
                   (IW'(grid_width) > IW'(MAX_WIDTH)) ? IW'(MAX_WIDTH) : IW'(grid_width);
    assign h_eff = (grid_height == 7'd0) ? IW'(1) :
                   (IW'(grid_height) > IW'(MAX_HEIGHT)) ? IW'(MAX_HEIGHT) : IW'(grid_height);

    function automatic logic signed [GW-1:0] gsat(input logic signed [63:0] p);
        logic signed [47:0] f;
        f = p[63:16];
        if (f > 48'(signed'(mgv_pkg::GPOS_MAX)))
        begin
            return mgv_pkg::GPOS_MAX;
        end
        else if (f < 48'(signed'(mgv_pkg::GPOS_MIN)))
        begin
            return mgv_pkg::GPOS_MIN;
        end
        return f[GW-1:0];
    endfunction

    function automatic logic [IW-1:0] nclamp(input logic signed [GE-1:0] g,
                                             input logic [IW-1:0] lim);
        logic signed [GE-17:0] f;
        f = g[GE-1:16];
        if (f < 0)
        begin
            return '0;
        end
        else if ({1'b0, f} >= (GE-15)'(lim))
        begin
            return lim - IW'(1);
        end
        return IW'(f);
    endfunction

    logic signed [GE-1:0] gxe, gye, gyh, gxh;
    logic [IW-1:0] ui_c, uj_c, vi_c, vj_c;
    assign gxe = {gx_reg[GW-1], gx_reg};
    assign gye = {gy_reg[GW-1], gy_reg};
    assign gyh = gye - GE'(mgv_pkg::HALF_Q16);
    assign gxh = gxe - GE'(mgv_pkg::HALF_Q16);
    assign ui_c = nclamp(gxe, w_eff);
    assign uj_c = nclamp(gyh, h_eff);
    assign vi_c = nclamp(gxh, w_eff);
    assign vj_c = nclamp(gye, h_eff);

    logic [IW-1:0] ci_u, cj_u, ci_v, cj_v;
    logic signed [WW-1:0] wx_u, wy_u, wx_v, wy_v;
    always_comb
    begin
        ci_u = (k_reg[0] && !ulx_reg) ? ui_reg + IW'(1) : ui_reg;
        cj_u = (k_reg[1] && !uly_reg) ? uj_reg + IW'(1) : uj_reg;
        ci_v = (k_reg[0] && !vlx_reg) ? vi_reg + IW'(1) : vi_reg;
        cj_v = (k_reg[1] && !vly_reg) ? vj_reg + IW'(1) : vj_reg;
        wx_u = k_reg[0] ? uwx1_reg : WW'(mgv_pkg::ONE_Q16) - uwx1_reg;
        wy_u = k_reg[1] ? uwy1_reg : WW'(mgv_pkg::ONE_Q16) - uwy1_reg;
        wx_v = k_reg[0] ? vwx1_reg : WW'(mgv_pkg::ONE_Q16) - vwx1_reg;
        wy_v = k_reg[1] ? vwy1_reg : WW'(mgv_pkg::ONE_Q16) - vwy1_reg;
    end

    always_comb
    begin
        ram_we = 1'b0;
        ram_addr_u = (AW'(q_item.cell_y) << XW) | AW'(q_item.cell_x);
        ram_addr_v = ram_addr_u;
        if (st_reg == S_IDLE)
        begin
            ram_we = q_valid && (q_item.command == mgv_pkg::CMD_WRITE)
                     && ({6'd0, q_item.cell_x} < 12'(MAX_WIDTH))
                     && ({6'd0, q_item.cell_y} < 12'(MAX_HEIGHT));
        end
        else
        begin
            ram_addr_u = {cj_u[YW-1:0], ci_u[XW-1:0]};
            ram_addr_v = {cj_v[YW-1:0], ci_v[XW-1:0]};
        end
    end

    mgv_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr_u),
        .wdata(q_item.data_u),
        .rdata(ru_data)
    );

    mgv_ram #(.WIDTH(32), .DEPTH(1 << AW)) v_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr_v),
        .wdata(q_item.data_v),
        .rdata(rv_data)
    );

    assign q_ready = (st_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_u = out_u_reg;
    assign out_v = out_v_reg;
    assign out_sat = out_sat_reg;

    logic signed [63:0] pmul;
    assign pmul = $signed((st_reg == S_MULX) ? py_reg : q_item.data_u)
                  * $signed({1'b0, inv_cell_size});

    logic signed [WW-1:0] wxk, wyk;
    assign wxk = kv_reg ? wx_v : wx_u;
    assign wyk = kv_reg ? wy_v : wy_u;

    // sample times weight product, split in two partial products
    logic signed [31:0] samp;
    logic signed [62:0] plo, phi;
    logic signed [ACW-1:0] pterm;
    assign samp = kv_reg ? rv_data : ru_data;
    assign plo = samp * $signed({1'b0, wxy_reg[28:0]});
    assign phi = samp * $signed(wxy_reg[2*WW-1:29]);
    assign pterm = (ACW'(phi) <<< 29) + ACW'(plo);

    function automatic logic signed [31:0] rsat(input logic signed [ACW-1:0] a,
                                                output logic s);
        logic signed [63:0] r;
        r = a[ACW-1:32];
        s = 1'b0;
        if (r > 64'sh7fffffff)
        begin
            s = 1'b1;
            return 32'sh7fffffff;
        end
        else if (r < -64'sh80000000)
        begin
            s = 1'b1;
            return -32'sh80000000;
        end
        return r[31:0];
    endfunction

    logic signed [31:0] fu, fv;
    logic su, sv;
    always_comb
    begin
        fu = rsat(acc_u_reg, su);
        fv = rsat(acc_v_reg, sv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            k_reg <= 2'd0;
            kv_reg <= 1'b0;
            acc_ph_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (st_reg == S_OUT && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE:
                begin
                    k_reg <= 2'd0;
                    if (q_valid && q_item.command == mgv_pkg::CMD_QUERY)
                    begin
                        st_reg <= S_MULX;
                    end
                end
                S_MULX:
                begin
                    k_reg <= 2'd1;
                    st_reg <= S_MULY;
                end
                S_MULY:
                begin
                    k_reg <= 2'd0;
                    st_reg <= S_NODE;
                end
                S_NODE:
                begin
                    st_reg <= S_RD;
                end
                S_RD:
                begin
                    st_reg <= S_ACC;
                    kv_reg <= 1'b0;
                    acc_ph_reg <= 1'b0;
                end
                S_ACC:
                begin
                    acc_ph_reg <= ~acc_ph_reg;
                    if (acc_ph_reg)
                    begin
                        kv_reg <= ~kv_reg;
                        if (kv_reg)
                        begin
                            if (k_reg == 2'd3)
                            begin
                                st_reg <= S_FIN;
                            end
                            else
                            begin
                                k_reg <= k_reg + 2'd1;
                                st_reg <= S_RD;
                            end
                        end
                    end
                end
                S_FIN:
                begin
                    st_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            S_IDLE:
            begin
                prod_reg <= pmul;
                py_reg <= q_item.data_v;
            end
            S_MULX:
            begin
                gx_reg <= gsat(prod_reg);
                prod_reg <= pmul;
            end
            S_MULY:
            begin
                gy_reg <= gsat(prod_reg);
            end
            S_NODE:
            begin
                ui_reg <= ui_c;
                uj_reg <= uj_c;
                vi_reg <= vi_c;
                vj_reg <= vj_c;
                ulx_reg <= (ui_c == w_eff - IW'(1));
                uly_reg <= (uj_c == h_eff - IW'(1));
                vlx_reg <= (vi_c == w_eff - IW'(1));
                vly_reg <= (vj_c == h_eff - IW'(1));
                uwx1_reg <= (ui_c == w_eff - IW'(1)) ? '0
                            : WW'(gxe) - WW'({ui_c, 16'd0});
                uwy1_reg <= (uj_c == h_eff - IW'(1)) ? '0
                            : WW'(gyh) - WW'({uj_c, 16'd0});
                vwx1_reg <= (vi_c == w_eff - IW'(1)) ? '0
                            : WW'(gxh) - WW'({vi_c, 16'd0});
                vwy1_reg <= (vj_c == h_eff - IW'(1)) ? '0
                            : WW'(gye) - WW'({vj_c, 16'd0});
                acc_u_reg <= '0;
                acc_v_reg <= '0;
            end
            S_ACC:
            begin
                if (!acc_ph_reg)
                begin
                    wxy_reg <= wxk * wyk;
                end
                else if (!kv_reg)
                begin
                    acc_u_reg <= acc_u_reg + pterm;
                end
                else
                begin
                    acc_v_reg <= acc_v_reg + pterm;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_u_reg <= fu;
                    out_v_reg <= fv;
                    out_sat_reg <= su | sv;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== design/mac_grid_velocity_bilinear_sample.sv =====
// channel  | dir | tdata (low bit up)                              | tuser
// s_axis   | in  | cell_x[5:0] cell_y[11:6] write_u[43:12]          | command
//          |     | write_v[75:44] pos_x[107:76] pos_y[139:108]      |
// m_axis   | out | vel_u[31:0] vel_v[63:32]                         | saturated
// apb      | in  | 0x0 grid_width, 0x4 grid_height, 0x8 inv_cell_size |
// a write is stored by the back end while it is idle and gives no word
// a query runs two scaling multiplies, node select, then
// four neighbor reads each followed by u and v weight products and accumulates
// a two-entry queue decouples the input; a waiting word holds the back end
// reset is asynchronous; the grid memories are not cleared
module mac_grid_velocity_bilinear_sample #(
    parameter int MAX_WIDTH = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,  // cell_x cell_y write_u write_v pos_x pos_y
    input  logic         s_axis_tuser,  // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // vel_u vel_v
    output logic         m_axis_tuser,  // saturated
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [6:0]  grid_width_reg;
    logic [6:0]  grid_height_reg;
    logic [31:0] inv_reg;
    mgv_pkg::item_t in_item, q_item;
    logic q_valid, q_ready;
    logic [31:0] vu, vv;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= 7'd64;
            grid_height_reg <= 7'd64;
            inv_reg <= 32'd65536;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                mgv_pkg::REG_WIDTH: grid_width_reg <= pwdata[6:0];
                mgv_pkg::REG_HEIGHT: grid_height_reg <= pwdata[6:0];
                mgv_pkg::REG_INV: inv_reg <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            mgv_pkg::REG_WIDTH: prdata = {25'd0, grid_width_reg};
            mgv_pkg::REG_HEIGHT: prdata = {25'd0, grid_height_reg};
            mgv_pkg::REG_INV: prdata = inv_reg;
            default: prdata = 32'd0;
        endcase
    end

    // query words carry positions in the sample slots
    always_comb
    begin
        in_item.command = s_axis_tuser;
        in_item.cell_x = s_axis_tdata[5:0];
        in_item.cell_y = s_axis_tdata[11:6];
        if (s_axis_tuser == mgv_pkg::CMD_WRITE)
        begin
            in_item.data_u = s_axis_tdata[43:12];
            in_item.data_v = s_axis_tdata[75:44];
        end
        else
        begin
            in_item.data_u = s_axis_tdata[107:76];
            in_item.data_v = s_axis_tdata[139:108];
        end
    end

    mgv_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    mgv_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .grid_width   (grid_width_reg),
        .grid_height  (grid_height_reg),
        .inv_cell_size(inv_reg),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_u        (vu),
        .out_v        (vv),
        .out_sat      (m_axis_tuser)
    );

    assign m_axis_tdata = {vv, vu};

endmodule

// ===== design/mgv_checker.sv =====
module mgv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        pready
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    a_user_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tuser))
        else $error("saturation flag changed while stalled");

    a_valid_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(m_axis_tvalid))
        else $error("output valid unknown");

    a_pready: assert property (@(posedge clk) pready)
        else $error("pready low");

endmodule

bind mac_grid_velocity_bilinear_sample mgv_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .pready       (pready)
);

// ===== verif/mac_grid_velocity_bilinear_sample_tb.sv =====
`timescale 1ns / 1ps

module mac_grid_velocity_bilinear_sample_tb;

    localparam int GRID_COLS = 64;
    localparam int GRID_ROWS = 64;
    localparam longint VEL_MAX = 64'sd2147483647;
    localparam longint VEL_MIN = -64'sd2147483648;
    localparam longint G_MAX = 64'sd134217727;
    localparam longint G_MIN = -64'sd134217728;

    typedef struct {
        logic        cmd;
        logic [5:0]  cx;
        logic [5:0]  cy;
        logic [31:0] wu;
        logic [31:0] wv;
        logic [31:0] px;
        logic [31:0] py;
    } word_t;

    typedef struct {
        logic [31:0] vu;
        logic [31:0] vv;
        logic        sat;
    } vel_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;  // cell_x cell_y write_u write_v pos_x pos_y
    logic         s_axis_tuser;  // command
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;  // vel_u vel_v
    logic         m_axis_tuser;  // saturated
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    mac_grid_velocity_bilinear_sample i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    word_t  pending_words[$];
    vel_t   expected_vel[$];
    logic [31:0] u_mem [GRID_COLS*GRID_ROWS];
    logic [31:0] v_mem [GRID_COLS*GRID_ROWS];
    bit     planned [GRID_COLS*GRID_ROWS];
    logic [6:0]  cfg_w;
    logic [6:0]  cfg_h;
    logic [31:0] cfg_inv;
    int     mismatches;
    int     words_queued;
    bit     calm;
    bit     s_acc;
    int     send_gap;
    int     recv_gap;
    int     hold_left;
    int     recv_cycles;

    always #6 clk = ~clk;

    function automatic longint eff_size(logic [6:0] v);
        if (v == 0)
            return 1;
        if (v > 64)
            return 64;
        return longint'(v);
    endfunction

    function automatic longint to_grid(logic [31:0] pos, logic [31:0] inv);
        longint g;
        g = (longint'($signed(pos)) * longint'({32'd0, inv})) >>> 16;
        if (g > G_MAX)
            g = G_MAX;
        if (g < G_MIN)
            g = G_MIN;
        return g;
    endfunction

    function automatic logic [31:0] face_blend(bit use_v, longint gx, longint gy,
                                               longint offx, longint offy,
                                               longint w, longint h, inout logic sat);
        longint i, j, i1, j1, wx0, wx1, wy0, wy1;
        longint s00, s10, s01, s11;
        logic signed [127:0] acc, a, b;
        i = (gx - offx) >>> 16;
        j = (gy - offy) >>> 16;
        i = (i < 0) ? 0 : ((i > w - 1) ? w - 1 : i);
        j = (j < 0) ? 0 : ((j > h - 1) ? h - 1 : j);
        wx1 = gx - (i * 65536 + offx);
        wx0 = 65536 - wx1;
        wy1 = gy - (j * 65536 + offy);
        wy0 = 65536 - wy1;
        i1 = (i + 1 < w) ? i + 1 : i;
        j1 = (j + 1 < h) ? j + 1 : j;
        if (i == w - 1)
        begin
            wx0 = 65536;
            wx1 = 0;
        end
        if (j == h - 1)
        begin
            wy0 = 65536;
            wy1 = 0;
        end
        s00 = use_v ? $signed(v_mem[j*GRID_COLS+i])   : $signed(u_mem[j*GRID_COLS+i]);
        s10 = use_v ? $signed(v_mem[j*GRID_COLS+i1])  : $signed(u_mem[j*GRID_COLS+i1]);
        s01 = use_v ? $signed(v_mem[j1*GRID_COLS+i])  : $signed(u_mem[j1*GRID_COLS+i]);
        s11 = use_v ? $signed(v_mem[j1*GRID_COLS+i1]) : $signed(u_mem[j1*GRID_COLS+i1]);
        a = s00; b = wx0 * wy0; acc = a * b;
        a = s10; b = wx1 * wy0; acc = acc + a * b;
        a = s01; b = wx0 * wy1; acc = acc + a * b;
        a = s11; b = wx1 * wy1; acc = acc + a * b;
        acc = acc >>> 32;
        if (acc > VEL_MAX)
        begin
            acc = VEL_MAX;
            sat = 1'b1;
        end
        if (acc < VEL_MIN)
        begin
            acc = VEL_MIN;
            sat = 1'b1;
        end
        return acc[31:0];
    endfunction

    function automatic void apply_word(word_t wd);
        vel_t   r;
        longint gx, gy, w, h;
        if (wd.cmd == mgv_pkg::CMD_WRITE)
        begin
            u_mem[wd.cy*GRID_COLS+wd.cx] = wd.wu;
            v_mem[wd.cy*GRID_COLS+wd.cx] = wd.wv;
            return;
        end
        w = eff_size(cfg_w);
        h = eff_size(cfg_h);
        gx = to_grid(wd.px, cfg_inv);
        gy = to_grid(wd.py, cfg_inv);
        r.sat = 1'b0;
        r.vu = face_blend(1'b0, gx, gy, 0, 32768, w, h, r.sat);
        r.vv = face_blend(1'b1, gx, gy, 32768, 0, w, h, r.sat);
        expected_vel.push_back(r);
    endfunction

    // input acceptance, prediction and output check
    always @(posedge clk)
    begin
        vel_t ex;
        s_acc <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            apply_word(pending_words[0]);
            void'(pending_words.pop_front());
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_vel.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: u=%h v=%h sat=%b",
                             m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
            end
            else
            begin
                ex = expected_vel.pop_front();
                if (ex.vu !== m_axis_tdata[31:0] || ex.vv !== m_axis_tdata[63:32]
                    || ex.sat !== m_axis_tuser)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp u=%h v=%h sat=%b got u=%h v=%h sat=%b",
                                 ex.vu, ex.vv, ex.sat, m_axis_tdata[31:0],
                                 m_axis_tdata[63:32], m_axis_tuser);
                end
            end
        end
    end

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || s_acc))
        begin
            if (send_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap--;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap = $urandom_range(1, 6) - 1;
            end
            else if (pending_words.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= pending_words[0].cmd;
                s_axis_tdata <= {4'd0, pending_words[0].py, pending_words[0].px,
                                 pending_words[0].wv, pending_words[0].wu,
                                 pending_words[0].cy, pending_words[0].cx};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            recv_cycles++;
            if (recv_cycles == 3000)
                hold_left = 400;
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (recv_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                recv_gap--;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                recv_gap = $urandom_range(1, 6) - 1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            mgv_pkg::REG_WIDTH:  cfg_w = val[6:0];
            mgv_pkg::REG_HEIGHT: cfg_h = val[6:0];
            default:             cfg_inv = val;
        endcase
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_write(logic [5:0] x, logic [5:0] y);
        word_t wd;
        wd.cmd = mgv_pkg::CMD_WRITE;
        wd.cx = x;
        wd.cy = y;
        wd.wu = pick_sample();
        wd.wv = pick_sample();
        wd.px = $urandom;
        wd.py = $urandom;
        planned[y*GRID_COLS+x] = 1'b1;
        pending_words.push_back(wd);
        words_queued++;
    endfunction

    function automatic void queue_query(logic [31:0] x, logic [31:0] y);
        word_t wd;
        wd.cmd = mgv_pkg::CMD_QUERY;
        wd.cx = 6'($urandom);
        wd.cy = 6'($urandom);
        wd.wu = $urandom;
        wd.wv = $urandom;
        wd.px = x;
        wd.py = y;
        pending_words.push_back(wd);
        words_queued++;
    endfunction

    function automatic logic [31:0] pick_pos(longint cells);
        longint g, p;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default:
            begin
                g = longint'($urandom_range(0, 32'((cells + 4) * 65536))) - 2 * 65536;
                if (cfg_inv == 0)
                    return $urandom;
                p = (g <<< 16) / longint'({32'd0, cfg_inv});
                if (p > VEL_MAX)
                    p = VEL_MAX;
                if (p < VEL_MIN)
                    p = VEL_MIN;
                return p[31:0];
            end
        endcase
    endfunction

    task automatic settle();
        while (pending_words.size() > 0 || expected_vel.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic run_phase(logic [6:0] w, logic [6:0] h, logic [31:0] inv, int ops);
        longint we, he;
        settle();
        reg_write(mgv_pkg::REG_WIDTH, {25'd0, w});
        reg_write(mgv_pkg::REG_HEIGHT, {25'd0, h});
        reg_write(mgv_pkg::REG_INV, inv);
        we = eff_size(w);
        he = eff_size(h);
        for (int j = 0; j < he; j++)
            for (int i = 0; i < we; i++)
                if (!planned[j*GRID_COLS+i] || $urandom_range(0, 3) == 0)
                    queue_write(6'(i), 6'(j));
        for (int k = 0; k < ops; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                queue_write(6'($urandom), 6'($urandom));
            else
                queue_query(pick_pos(we), pick_pos(he));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_w = 7'd64;
        cfg_h = 7'd64;
        cfg_inv = 32'h10000;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: corners, last column, last row, last cell, extremes
        run_phase(7'd4, 7'd3, 32'h10000, 0);
        queue_query(32'h0, 32'h0);
        queue_query(32'h0003_8000, 32'h0001_0000);
        queue_query(32'h0001_0000, 32'h0002_8000);
        queue_query(32'h0004_0000, 32'h0003_0000);
        queue_query(32'h0003_c000, 32'h0002_c000);
        queue_query(32'hfffe_0000, 32'hffff_0000);
        queue_query(32'h7fffffff, 32'h7fffffff);
        queue_query(32'h80000000, 32'h80000000);
        queue_query(32'h7fffffff, 32'h80000000);
        queue_query(32'h0008_0000, 32'hfff0_0000);
        queue_write(6'd63, 6'd63);
        queue_query(32'h0001_8000, 32'h0001_8000);
        run_phase(7'd1, 7'd1, 32'h10000, 12);
        run_phase(7'd0, 7'd0, 32'h0, 12);
        run_phase(7'd127, 7'd1, 32'h8000, 60);
        run_phase(7'd1, 7'd64, 32'h20000, 60);
        run_phase(7'd64, 7'd2, 32'hffffffff, 40);
        run_phase(7'd2, 7'd64, 32'h1, 40);
        while (words_queued < 1450)
        begin
            case ($urandom_range(0, 2))
                0: run_phase(7'd64, 7'($urandom_range(1, 3)),
                             $urandom_range(16384, 262144), 80);
                1: run_phase(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)),
                             $urandom, 80);
                default: run_phase(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)),
                                   $urandom_range(16384, 262144), 100);
            endcase
        end
        settle();
        calm = 1'b1;
        run_phase(7'd3, 7'd5, 32'h18000, 150);
        settle();
        if (mismatches == 0 && expected_vel.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mgv_pkg.sv
design/mgv_ram.sv
design/mgv_front.sv
design/mgv_back.sv
design/mac_grid_velocity_bilinear_sample.sv
design/mgv_checker.sv
verif/mac_grid_velocity_bilinear_sample_tb.sv
